[hw/rtl/bbl_pkg.sv]
// ---------------------------------------------------------------------------
// bbl_pkg
// Shared types, constants and rounding arithmetic of the 3x3 box blur.
// ---------------------------------------------------------------------------
`default_nettype none

package bbl_pkg;

  localparam int CH_W         = 8;
  localparam int PIX_W        = 3 * CH_W;
  localparam int SUM_W        = 12;          // 9 * 255 fits
  localparam int CNT_W        = 4;           // neighbor count 1..9

  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;

  localparam int OUT_DEPTH   = 4;
  localparam int MAX_RESULTS = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // reciprocals: floor(y/3) = (y*RECIP3) >> 13, floor(y/9) = (y*RECIP9) >> 15, y < 4096
  localparam logic [SUM_W-1:0] RECIP3       = 12'd2731;
  localparam int               RECIP3_SHIFT = 13;
  localparam logic [SUM_W-1:0] RECIP9       = 12'd3641;
  localparam int               RECIP9_SHIFT = 15;

  typedef logic [PIX_W-1:0] bbl_pix_t;
  typedef logic [2:0][2:0][PIX_W-1:0] bbl_window_t;  // [row][col], row 0 above, col 0 left

  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic frame_end;
    logic run_last;
  } bbl_emit_ctl_t;

  typedef struct packed {
    logic            frame_end;
    logic            run_last;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } bbl_result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PIX_SHIFT,
    S_EMIT_A,
    S_EMIT_B,
    S_DR_PRE,
    S_DR_SHIFT,
    S_DR_EMIT
  } bbl_state_t;

  // Round half up: (2*sum + n) div (2*n), n in {1,2,3,4,6,9}.
  function automatic logic [CH_W-1:0] round_mean(input logic [SUM_W-1:0] sum,
                                                 input logic [CNT_W-1:0] cnt);
    logic [SUM_W:0]     x;
    logic [SUM_W-1:0]   y;
    logic [2*SUM_W-1:0] prod;
    logic [SUM_W:0]     q;
    x    = {sum, 1'b0} + (SUM_W+1)'(cnt);
    y    = '0;
    prod = '0;
    case (cnt)
      4'd1: q = x >> 1;
      4'd2: q = x >> 2;
      4'd4: q = x >> 3;
      4'd3: begin
        y    = x[SUM_W:1];
        prod = y * RECIP3;
        q    = (SUM_W+1)'(prod >> RECIP3_SHIFT);
      end
      4'd6: begin
        y    = SUM_W'(x[SUM_W:2]);
        prod = y * RECIP3;
        q    = (SUM_W+1)'(prod >> RECIP3_SHIFT);
      end
      4'd9: begin
        y    = x[SUM_W:1];
        prod = y * RECIP9;
        q    = (SUM_W+1)'(prod >> RECIP9_SHIFT);
      end
      default: q = '0;
    endcase
    return q[CH_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/bbl_line_ram.sv]
// ---------------------------------------------------------------------------
// bbl_line_ram
// One row bank: synchronous RAM, one write and one read port, read-first.
// ---------------------------------------------------------------------------
`default_nettype none

module bbl_line_ram #(
  parameter int DEPTH = bbl_pkg::DEF_MAX_WIDTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [bbl_pkg::PIX_W-1:0] wdata,
  input  logic [AW-1:0]            raddr,
  output logic [bbl_pkg::PIX_W-1:0] rdata
);
  import bbl_pkg::*;

  bbl_pix_t mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/bbl_mean.sv]
// ---------------------------------------------------------------------------
// bbl_mean
// Two-stage arithmetic: masked 3x3 channel sums, then rounded division.
// ---------------------------------------------------------------------------
`default_nettype none

module bbl_mean (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  emit_valid,
  input  bbl_pkg::bbl_emit_ctl_t emit_ctl,
  input  bbl_pkg::bbl_window_t   cells,
  output logic                  res_valid,
  output bbl_pkg::bbl_result_t   res
);
  import bbl_pkg::*;

  logic             s1_valid_r;
  logic [SUM_W-1:0] sum_red_r, sum_grn_r, sum_blu_r;
  logic [SUM_W-1:0] sum_red_nxt, sum_grn_nxt, sum_blu_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             fe_r, rl_r;
  logic [2:0]       row_ok, col_ok;
  logic             res_valid_r;
  bbl_result_t      res_r;

  assign row_ok = {emit_ctl.bot_ok, 1'b1, emit_ctl.top_ok};
  assign col_ok = {emit_ctl.right_ok, 1'b1, emit_ctl.left_ok};

  // masked sums; out-of-frame neighbors drop out
  always_comb begin
    sum_red_nxt = '0;
    sum_grn_nxt = '0;
    sum_blu_nxt = '0;
    cnt_nxt     = '0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        if (row_ok[a] && col_ok[b]) begin
          sum_red_nxt = sum_red_nxt + SUM_W'(cells[a][b][PIX_W-1 -: CH_W]);
          sum_grn_nxt = sum_grn_nxt + SUM_W'(cells[a][b][2*CH_W-1 -: CH_W]);
          sum_blu_nxt = sum_blu_nxt + SUM_W'(cells[a][b][CH_W-1:0]);
          cnt_nxt     = cnt_nxt + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= emit_valid;
      res_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    sum_red_r       <= sum_red_nxt;
    sum_grn_r       <= sum_grn_nxt;
    sum_blu_r       <= sum_blu_nxt;
    cnt_r           <= cnt_nxt;
    fe_r            <= emit_ctl.frame_end;
    rl_r            <= emit_ctl.run_last;
    res_r.frame_end <= fe_r;
    res_r.run_last  <= rl_r;
    res_r.red       <= round_mean(sum_red_r, cnt_r);
    res_r.green     <= round_mean(sum_grn_r, cnt_r);
    res_r.blue      <= round_mean(sum_blu_r, cnt_r);
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

[hw/rtl/bbl_out_buf.sv]
// ---------------------------------------------------------------------------
// bbl_out_buf
// Small result FIFO between the arithmetic pipeline and the output port.
// ---------------------------------------------------------------------------
`default_nettype none

module bbl_out_buf #(
  parameter int DEPTH = bbl_pkg::OUT_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  input  bbl_pkg::bbl_result_t wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output bbl_pkg::bbl_result_t rd_data
);
  import bbl_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bbl_result_t   fifo_mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          rd_xfer;

  assign rd_valid = (count_r != '0);
  assign rd_data  = fifo_mem_r[rd_ptr_r];
  assign rd_xfer  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_valid) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (rd_xfer) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      case ({wr_valid, rd_xfer})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid) begin
      fifo_mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/box_blur_3x3_edge_aware_unit.sv]
// ---------------------------------------------------------------------------
// box_blur_3x3_edge_aware_unit
// Streaming 3x3 box blur over RGB pixels with edge-aware divisor.
// ---------------------------------------------------------------------------
// Path: each result leaves the sequencer in S_EMIT_A, S_EMIT_B or S_DR_EMIT, passes the
//   mean stages and is written to the output FIFO, which raises out_tvalid.
// Sequencing: one item at a time; a pixel walks S_IDLE, S_PIX_SHIFT, then S_EMIT_A and/or
//   S_EMIT_B as it has results; a drain tick walks S_IDLE, S_DR_SHIFT and S_DR_EMIT, the
//   first of a frame with S_DR_PRE ahead of S_DR_SHIFT, as the row RAM walk requires.
// Reset: rst_n synchronous, active low; frame size returns to 640 x 480 (clamped),
//   positions and output FIFO clear. Row RAM contents are not cleared.
`default_nettype none

module box_blur_3x3_edge_aware_unit #(
  parameter int MAX_WIDTH  = bbl_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbl_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bbl_pkg::PIX_W-1:0]       in_tdata,   // [7:0] in_red, [15:8] in_green,
                                                      // [23:16] in_blue
  input  logic                            in_tuser,   // [0] op
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bbl_pkg::PIX_W-1:0]       out_tdata,  // [7:0] out_red, [15:8] out_green,
                                                      // [23:16] out_blue
  output logic                            out_tlast,  // frame_end
  output logic                            out_tuser,  // [0] run_last
  // configuration writes
  input  logic                            cfg_we,
  input  logic [bbl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bbl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bbl_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);    // holds 0..MAX_WIDTH
  localparam int RW = $clog2(MAX_HEIGHT + 1);   // holds 0..MAX_HEIGHT
  localparam int CI = $clog2(MAX_WIDTH);        // column address
  localparam int RC = $clog2(OUT_DEPTH + 1);
  localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

  // control state
  bbl_state_t    state_r, state_nxt;
  logic [WW-1:0] width_r, width_nxt;
  logic [RW-1:0] height_r, height_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [WW-1:0] in_col_r, in_col_nxt;
  logic [WW-1:0] out_col_r, out_col_nxt;
  logic [RC-1:0] reserved_r, reserved_nxt;

  // per-item context and window
  bbl_pix_t      pix_r, pix_nxt;
  logic          sel_r, sel_nxt;          // 1: window's top row lives in bank 1
  logic          top_ok_r, top_ok_nxt;
  logic          left_a_r, left_a_nxt;
  logic          left_b_r, left_b_nxt;
  logic          emit_a_r, emit_a_nxt;
  logic          emit_b_r, emit_b_nxt;
  bbl_window_t   win_r, win_nxt;

  // datapath nets
  bbl_pix_t      pix_in;
  bbl_pix_t      rd0, rd1, rd_top, rd_mid;
  logic [CI-1:0] raddr, drain_addr;
  logic          we0, we1;
  logic [WW-1:0] col_inc, out_col_inc;
  logic          do_shift;
  logic          in_xfer, out_xfer;
  logic          emit_valid;
  bbl_emit_ctl_t emit_ctl;
  bbl_window_t   emit_cells;
  logic          res_valid;
  bbl_result_t   res;
  bbl_result_t   out_res;
  logic [CFG_WIDTH_W-1:0]  cfg_w_raw;
  logic [CFG_HEIGHT_W-1:0] cfg_h_raw;
  logic [WW-1:0] w_clamp;
  logic [RW-1:0] h_clamp;

  // internal pixel order is {red, green, blue}
  assign pix_in = {in_tdata[CH_W-1:0], in_tdata[2*CH_W-1 -: CH_W], in_tdata[PIX_W-1 -: CH_W]};

  assign rd_top      = sel_r ? rd1 : rd0;
  assign rd_mid      = sel_r ? rd0 : rd1;
  assign col_inc     = in_col_r + WW'(1);
  assign out_col_inc = out_col_r + WW'(1);
  // right neighbor column of the drain position; off the frame it is masked anyway
  assign drain_addr  = (out_col_inc < width_r) ? out_col_inc[CI-1:0] : '0;
  assign in_xfer     = in_tvalid && in_tready;
  assign out_xfer    = out_tvalid && out_tready;

  // clamp register writes: zero acts as one, anything above the maximum as the maximum
  assign cfg_w_raw = cfg_data[CFG_WIDTH_W-1:0];
  assign cfg_h_raw = cfg_data[CFG_HEIGHT_W-1:0];

  always_comb begin
    if (cfg_w_raw == '0) begin
      w_clamp = WW'(1);
    end else if (cfg_w_raw > MAX_WIDTH) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(cfg_w_raw);
    end
    if (cfg_h_raw == '0) begin
      h_clamp = RW'(1);
    end else if (cfg_h_raw > MAX_HEIGHT) begin
      h_clamp = RW'(MAX_HEIGHT);
    end else begin
      h_clamp = RW'(cfg_h_raw);
    end
  end

  // Sequencer. Each pixel writes its bank (row parity) and reads the two
  // banks at its column: one holds row r-2, the other row r-1. After the
  // window slides, up to two results go to the mean pipeline. Drain ticks
  // walk the last row, reading one column ahead of the output position.
  always_comb begin
    state_nxt    = state_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    in_row_nxt   = in_row_r;
    in_col_nxt   = in_col_r;
    out_col_nxt  = out_col_r;
    pix_nxt      = pix_r;
    sel_nxt      = sel_r;
    top_ok_nxt   = top_ok_r;
    left_a_nxt   = left_a_r;
    left_b_nxt   = left_b_r;
    emit_a_nxt   = emit_a_r;
    emit_b_nxt   = emit_b_r;
    in_tready    = 1'b0;
    we0          = 1'b0;
    we1          = 1'b0;
    raddr        = drain_addr;
    do_shift     = 1'b0;
    emit_valid   = 1'b0;
    emit_ctl     = '0;
    emit_cells   = win_r;

    case (state_r)
      S_IDLE: begin
        // admit an item only if the FIFO can take all it may produce
        in_tready = (reserved_r <= RC'(OUT_DEPTH - MAX_RESULTS));
        if (in_tuser == OP_PIXEL) begin
          raddr = in_col_r[CI-1:0];
        end else if (out_col_r == '0) begin
          raddr = '0;
        end
        if (in_xfer) begin
          if (in_tuser == OP_PIXEL) begin
            // drop pixels once the frame is complete
            if (in_row_r < height_r && in_col_r < width_r) begin
              we0        = !in_row_r[0];
              we1        = in_row_r[0];
              sel_nxt    = in_row_r[0];
              pix_nxt    = pix_in;
              top_ok_nxt = (in_row_r >= RW'(2));
              left_a_nxt = (in_col_r >= WW'(2));
              left_b_nxt = (in_col_r >= WW'(1));
              emit_a_nxt = (in_row_r >= RW'(1)) && (in_col_r >= WW'(1));
              emit_b_nxt = (in_row_r >= RW'(1)) && (col_inc == width_r);
              if (col_inc >= width_r) begin
                in_col_nxt = '0;
                in_row_nxt = in_row_r + RW'(1);
              end else begin
                in_col_nxt = col_inc;
              end
              state_nxt = S_PIX_SHIFT;
            end
          end else begin
            // drain only once the whole frame is in
            if (in_row_r >= height_r && out_col_r < width_r) begin
              sel_nxt   = height_r[0];
              state_nxt = (out_col_r == '0) ? S_DR_PRE : S_DR_SHIFT;
            end
          end
        end
      end

      S_PIX_SHIFT: begin
        do_shift = 1'b1;
        if (emit_a_r) begin
          state_nxt = S_EMIT_A;
        end else if (emit_b_r) begin
          state_nxt = S_EMIT_B;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_EMIT_A: begin
        // centered on the previous column of the row above
        emit_valid         = 1'b1;
        emit_ctl.top_ok    = top_ok_r;
        emit_ctl.bot_ok    = 1'b1;
        emit_ctl.left_ok   = left_a_r;
        emit_ctl.right_ok  = 1'b1;
        emit_ctl.run_last  = !emit_b_r;
        state_nxt          = emit_b_r ? S_EMIT_B : S_IDLE;
      end

      S_EMIT_B: begin
        // last column of the row above: view the window one column over
        for (int a = 0; a < 3; a++) begin
          emit_cells[a][0] = win_r[a][1];
          emit_cells[a][1] = win_r[a][2];
          emit_cells[a][2] = win_r[a][2];
        end
        emit_valid         = 1'b1;
        emit_ctl.top_ok    = top_ok_r;
        emit_ctl.bot_ok    = 1'b1;
        emit_ctl.left_ok   = left_b_r;
        emit_ctl.run_last  = 1'b1;
        state_nxt          = S_IDLE;
      end

      S_DR_PRE: begin
        // column 0 arrives; fetch column 1
        do_shift  = 1'b1;
        state_nxt = S_DR_SHIFT;
      end

      S_DR_SHIFT: begin
        do_shift  = 1'b1;
        state_nxt = S_DR_EMIT;
      end

      S_DR_EMIT: begin
        emit_valid         = 1'b1;
        emit_ctl.top_ok    = (height_r >= RW'(2));
        emit_ctl.left_ok   = (out_col_r != '0);
        emit_ctl.right_ok  = (out_col_inc < width_r);
        emit_ctl.frame_end = (out_col_inc == width_r);
        emit_ctl.run_last  = 1'b1;
        if (out_col_inc >= width_r) begin
          // frame done: restart positions
          in_row_nxt  = '0;
          in_col_nxt  = '0;
          out_col_nxt = '0;
        end else begin
          out_col_nxt = out_col_inc;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // any register write restarts the frame
    if (cfg_we) begin
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_col_nxt = '0;
      case (cfg_index)
        REG_FRAME_WIDTH:  width_nxt  = w_clamp;
        REG_FRAME_HEIGHT: height_nxt = h_clamp;
        default: ;
      endcase
    end
  end

  // slide the window left and bring in the fetched column
  always_comb begin
    win_nxt = win_r;
    if (do_shift) begin
      for (int a = 0; a < 3; a++) begin
        win_nxt[a][0] = win_r[a][1];
        win_nxt[a][1] = win_r[a][2];
      end
      win_nxt[0][2] = rd_top;
      win_nxt[1][2] = rd_mid;
      win_nxt[2][2] = pix_r;
    end
  end

  // reserved slots: results in the pipeline plus those held in the FIFO
  always_comb begin
    case ({emit_valid, out_xfer})
      2'b10:   reserved_nxt = reserved_r + RC'(1);
      2'b01:   reserved_nxt = reserved_r - RC'(1);
      default: reserved_nxt = reserved_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      width_r    <= WW'(RST_W);
      height_r   <= RW'(RST_H);
      in_row_r   <= '0;
      in_col_r   <= '0;
      out_col_r  <= '0;
      reserved_r <= '0;
    end else begin
      state_r    <= state_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      out_col_r  <= out_col_nxt;
      reserved_r <= reserved_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r    <= pix_nxt;
    sel_r    <= sel_nxt;
    top_ok_r <= top_ok_nxt;
    left_a_r <= left_a_nxt;
    left_b_r <= left_b_nxt;
    emit_a_r <= emit_a_nxt;
    emit_b_r <= emit_b_nxt;
    win_r    <= win_nxt;
  end

  // row banks: even rows in bank 0, odd rows in bank 1
  bbl_line_ram #(
    .DEPTH (MAX_WIDTH)
  ) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (in_col_r[CI-1:0]),
    .wdata (pix_in),
    .raddr (raddr),
    .rdata (rd0)
  );

  bbl_line_ram #(
    .DEPTH (MAX_WIDTH)
  ) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (in_col_r[CI-1:0]),
    .wdata (pix_in),
    .raddr (raddr),
    .rdata (rd1)
  );

  bbl_mean u_mean (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit_valid (emit_valid),
    .emit_ctl   (emit_ctl),
    .cells      (emit_cells),
    .res_valid  (res_valid),
    .res        (res)
  );

  bbl_out_buf #(
    .DEPTH (OUT_DEPTH)
  ) u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (res_valid),
    .wr_data  (res),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (out_res)
  );

  assign out_tdata = {out_res.blue, out_res.green, out_res.red};
  assign out_tlast = out_res.frame_end;
  assign out_tuser = out_res.run_last;

endmodule

`default_nettype wire

[hw/rtl/bbl_port_checker.sv]
// ---------------------------------------------------------------------------
// bbl_port_checker
// Port-level checks on the result stream of the box blur unit.
// ---------------------------------------------------------------------------
`default_nettype none

module bbl_port_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [bbl_pkg::PIX_W-1:0] out_tdata,
  input logic                      out_tlast,
  input logic                      out_tuser
);
  import bbl_pkg::*;

  // a stalled result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  // reset empties the result path
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // frame end comes from a drain tick, which gives exactly one result
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("frame end without run last");

endmodule

bind box_blur_3x3_edge_aware_unit bbl_port_checker u_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire

[dv/tb_box_blur_3x3_edge_aware_unit.sv]
// ---------------------------------------------------------------------------
// tb_box_blur_3x3_edge_aware_unit
// Self-checking bench for the streaming 3x3 edge-aware box blur. A queue of
// pixel and drain transfers feeds a bursty driver; each accepted transfer
// runs through a line-store/window predictor, and a monitor behind a
// stalling receiver compares every result with the oldest prediction.
// ---------------------------------------------------------------------------

module tb_box_blur_3x3_edge_aware_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bbl_pkg::*;

  localparam int CYCLE_LIMIT = 600_000;
  localparam int IDLE_GAP    = 16;     // well past the worst-case latency
  localparam int RAND_ITEMS  = 400;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic            op;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } blur_item_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [PIX_W-1:0]       in_tdata   = '0;
  logic                   in_tuser   = OP_PIXEL;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [PIX_W-1:0]       out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;
  logic                   cfg_we     = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  box_blur_3x3_edge_aware_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Blur predictor: its own frame registers, line store and 3x3 window.
  // -------------------------------------------------------------------------
  int unsigned reg_width, reg_height;
  int unsigned pos_in_row, pos_in_col, pos_out_col;
  bbl_pix_t    line_mem [0:2*DEF_MAX_WIDTH-1];
  bbl_window_t win;

  blur_item_t  pend_q [$];       // transfers waiting for the driver
  bbl_result_t blur_exp_q [$];   // blurred pixels still to come out

  int unsigned err_count    = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_cnt    = 0;
  bit          took_item    = 1'b0;
  int unsigned hold_left    = 0;

  function automatic int unsigned act_width();
    if (reg_width < 1) return 1;
    if (reg_width > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return reg_width;
  endfunction

  function automatic int unsigned act_height();
    if (reg_height < 1) return 1;
    if (reg_height > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
    return reg_height;
  endfunction

  // Two banks, picked by row parity.
  function automatic int unsigned line_slot(input int unsigned row, input int unsigned col);
    return ((row & 1) * DEF_MAX_WIDTH + col) % (2 * DEF_MAX_WIDTH);
  endfunction

  // Mean over the neighbors that lie inside the frame, rounded half up.
  function automatic bbl_result_t nbhd_mean(input bbl_window_t nb, input int unsigned i,
                                            input int unsigned j, input int unsigned w,
                                            input int unsigned h);
    int unsigned sr, sg, sb, n;
    int          a, b;
    bit          rv, cv;
    bbl_pix_t    p;
    bbl_result_t res;
    sr = 0; sg = 0; sb = 0; n = 0;
    for (a = 0; a < 3; a++) begin
      rv = (a == 1) || (a == 0 && i >= 1) || (a == 2 && i + 1 < h);
      for (b = 0; b < 3; b++) begin
        cv = (b == 1) || (b == 0 && j >= 1) || (b == 2 && j + 1 < w);
        if (rv && cv) begin
          p  = nb[a][b];
          sr += p[7:0];
          sg += p[15:8];
          sb += p[23:16];
          n++;
        end
      end
    end
    res.red       = CH_W'((2 * sr + n) / (2 * n));
    res.green     = CH_W'((2 * sg + n) / (2 * n));
    res.blue      = CH_W'((2 * sb + n) / (2 * n));
    res.frame_end = (i + 1 == h) && (j + 1 == w);
    res.run_last  = 1'b0;
    return res;
  endfunction

  task automatic blur_reset();
    int k;
    for (k = 0; k < 2 * DEF_MAX_WIDTH; k++) line_mem[k] = '0;
    win         = '0;
    reg_width   = RESET_WIDTH;
    reg_height  = RESET_HEIGHT;
    pos_in_row  = 0;
    pos_in_col  = 0;
    pos_out_col = 0;
  endtask

  // Advance the predictor by one accepted transfer and queue its results.
  task automatic blur_accept(input blur_item_t it);
    int unsigned w, h, r, c, j, col;
    int          a, cnt;
    bbl_window_t nb;
    bbl_result_t res0, res1;
    w   = act_width();
    h   = act_height();
    cnt = 0;
    if (it.op == OP_PIXEL) begin
      r = pos_in_row;
      c = pos_in_col;
      // a pixel after the frame is complete is dropped
      if (r < h && c < w) begin
        for (a = 0; a < 3; a++) begin
          win[a][0] = win[a][1];
          win[a][1] = win[a][2];
        end
        win[0][2] = line_mem[line_slot(r, c)];
        win[1][2] = line_mem[line_slot(r + 1, c)];
        win[2][2] = {it.blue, it.green, it.red};
        line_mem[line_slot(r, c)] = {it.blue, it.green, it.red};
        if (r >= 1 && c >= 1) begin
          res0        = nbhd_mean(win, r - 1, c - 1, w, h);
          cnt         = 1;
          pos_out_col = (pos_out_col + 1 >= w) ? 0 : pos_out_col + 1;
        end
        // row end also releases the last column of the row above
        if (r >= 1 && c + 1 == w) begin
          for (a = 0; a < 3; a++) begin
            nb[a][0] = win[a][1];
            nb[a][1] = win[a][2];
            nb[a][2] = '0;
          end
          if (cnt == 0) res0 = nbhd_mean(nb, r - 1, c, w, h);
          else          res1 = nbhd_mean(nb, r - 1, c, w, h);
          cnt++;
          pos_out_col = (pos_out_col + 1 >= w) ? 0 : pos_out_col + 1;
        end
        c++;
        if (c >= w) begin
          c = 0;
          r++;
        end
        pos_in_row = r;
        pos_in_col = c;
      end
    end else begin
      j = pos_out_col;
      // drains count only once the whole frame is in
      if (pos_in_row >= h && j < w) begin
        for (a = 0; a < 3; a++) begin
          if ((a == 0 && j < 1) || (a == 2 && j + 1 >= w)) begin
            nb[0][a] = '0;
            nb[1][a] = '0;
          end else begin
            col      = j + a - 1;
            nb[0][a] = line_mem[line_slot(h, col)];
            nb[1][a] = line_mem[line_slot(h - 1, col)];
          end
          nb[2][a] = '0;
        end
        res0        = nbhd_mean(nb, h - 1, j, w, h);
        cnt         = 1;
        pos_out_col = j + 1;
        if (pos_out_col >= w) begin
          pos_in_row  = 0;
          pos_in_col  = 0;
          pos_out_col = 0;
        end
      end
    end
    if (cnt == 1) begin
      res0.run_last = 1'b1;
      blur_exp_q.push_back(res0);
    end else if (cnt == 2) begin
      res1.run_last = 1'b1;
      blur_exp_q.push_back(res0);
      blur_exp_q.push_back(res1);
    end
  endtask

  // -------------------------------------------------------------------------
  // Input side: take transfers at the rising edge, drive at the falling edge.
  // -------------------------------------------------------------------------
  blur_item_t  head;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      blur_accept(pend_q.pop_front());
      took_item = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !took_item) begin
      // hold the offered transfer until the block takes it
    end else begin
      took_item = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        head = pend_q[0];
        in_tvalid <= 1'b1;
        in_tuser  <= head.op;
        in_tdata  <= {head.blue, head.green, head.red};
        // close the burst: a fresh length and, often, a gap after it
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Output side: receiver stall pattern plus an optional long hold-off.
  // -------------------------------------------------------------------------
  logic [31:0] rx_pat   = '0;
  logic [4:0]  rx_phase = '0;
  logic [1:0]  rx_mode  = '0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_phase == 0) begin
        rx_pat  = $urandom;
        rx_mode = $urandom_range(0, 3);
      end
      // modes 0 and 1 never stall; the others follow the random pattern
      out_tready <= (rx_mode < 2) ? 1'b1 : rx_pat[rx_phase];
      rx_phase = rx_phase + 1'b1;
    end
  end

  bbl_result_t want;

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h", $realtime, results_seen, what,
             got, exp_val);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (blur_exp_q.size() == 0) begin
        report_mismatch("result with none pending, tdata", out_tdata, 0);
      end else begin
        want = blur_exp_q.pop_front();
        if (out_tdata[7:0] !== want.red)     report_mismatch("red", out_tdata[7:0], want.red);
        if (out_tdata[15:8] !== want.green)
          report_mismatch("green", out_tdata[15:8], want.green);
        if (out_tdata[23:16] !== want.blue)
          report_mismatch("blue", out_tdata[23:16], want.blue);
        if (out_tlast !== want.frame_end)
          report_mismatch("frame_end", out_tlast, want.frame_end);
        if (out_tuser !== want.run_last)
          report_mismatch("run_last", out_tuser, want.run_last);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("box_blur_3x3_edge_aware_unit: mismatch");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b);
    blur_item_t it;
    it.op    = OP_PIXEL;
    it.red   = r;
    it.green = g;
    it.blue  = b;
    pend_q.push_back(it);
  endtask

  // Color fields on a drain are don't-care; fill them with noise.
  task automatic push_drain();
    blur_item_t it;
    it.op    = OP_DRAIN;
    it.red   = CH_W'($urandom);
    it.green = CH_W'($urandom);
    it.blue  = CH_W'($urandom);
    pend_q.push_back(it);
  endtask

  // Config may only change once the stream is empty and every result is out.
  task automatic wait_idle();
    @(posedge clk);
    while (pend_q.size() != 0 || in_tvalid || blur_exp_q.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    if (idx == REG_FRAME_WIDTH) reg_width  = val % (1 << CFG_WIDTH_W);
    else                        reg_height = val % (1 << CFG_HEIGHT_W);
    // any write restarts the frame
    pos_in_row  = 0;
    pos_in_col  = 0;
    pos_out_col = 0;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned k, fw, fh, npix, cut, good_items, w_new, h_new, kind;
    bit          frame_open;

    blur_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain with no frame pending at the reset size: dropped
    push_drain();
    wait_idle();

    // 3x3 frame: corners, edges and the one full interior neighborhood
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    for (k = 0; k < 9; k++)
      push_pixel(k[0] ? 8'hFF : 8'h00, (k < 5) ? 8'hFF : 8'h00, (k == 4) ? 8'h00 : 8'hFF);
    push_pixel(8'h5A, 8'hA5, 8'h3C);   // pixel while draining: dropped
    for (k = 0; k < 3; k++) push_drain();
    push_drain();                      // nothing left to drain: dropped
    wait_idle();

    // zero sizes act as a 1x1 frame
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 0);
    push_pixel(8'hA5, 8'h5A, 8'hC3);
    push_drain();
    wait_idle();

    // back-pressure frame: receiver holds off while the sender keeps going
    write_reg(REG_FRAME_WIDTH, 8);
    write_reg(REG_FRAME_HEIGHT, 6);
    @(posedge clk);
    hold_left = LONG_HOLD;
    for (k = 0; k < 48; k++) push_pixel(rand_chan(), rand_chan(), rand_chan());
    for (k = 0; k < 8; k++) push_drain();
    good_items = 56;
    wait_idle();

    // oversize registers clamp to the maximum; leave the frame open after a short run
    write_reg(REG_FRAME_WIDTH, (1 << CFG_DATA_W) - 1);
    write_reg(REG_FRAME_HEIGHT, (1 << CFG_DATA_W) - 1);
    for (k = 0; k < 16; k++) begin
      push_pixel(rand_chan(), rand_chan(), rand_chan());
      good_items++;
    end
    frame_open = 1'b1;

    // random frames: mostly complete, some abandoned, some stray transfers
    while (good_items < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w_new = 0;
        1:       w_new = 1;
        2:       w_new = 2;
        default: w_new = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 9))
        0:       h_new = 0;
        1:       h_new = 1;
        2:       h_new = 2;
        default: h_new = $urandom_range(3, 6);
      endcase
      kind = $urandom_range(0, 3);
      if (frame_open || kind != 0) begin
        wait_idle();
        // upper data bits beyond the width register must be dropped
        if (frame_open || kind != 2)
          write_reg(REG_FRAME_WIDTH, w_new | ($urandom_range(0, 3) << CFG_WIDTH_W));
        if (frame_open || kind != 1)
          write_reg(REG_FRAME_HEIGHT, h_new);
        frame_open = 1'b0;
      end
      fw   = act_width();
      fh   = act_height();
      npix = fw * fh;
      cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, npix) : npix;
      for (k = 0; k < cut; k++) begin
        push_pixel(rand_chan(), rand_chan(), rand_chan());
        good_items++;
        if (k + 1 < npix && $urandom_range(0, 24) == 0) push_drain();
      end
      if (cut < npix) begin
        frame_open = 1'b1;
      end else begin
        for (k = 0; k < fw; k++) begin
          if ($urandom_range(0, 9) == 0) push_pixel(rand_chan(), rand_chan(), rand_chan());
          push_drain();
          good_items++;
        end
        if ($urandom_range(0, 4) == 0) push_drain();
      end
    end

    wait_idle();
    if (err_count == 0) begin
      $display("box_blur_3x3_edge_aware_unit: match");
    end else begin
      $display("box_blur_3x3_edge_aware_unit: mismatch");
    end
    $finish;
  end

endmodule
